@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file cau_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CAU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// implication checked in the same cycle
`define CAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/cau_pkg.sv @@
// shared types and constants of the complex arithmetic unit
// no dependencies
`timescale 1ns / 1ps
package cau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_NE  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  localparam int unsigned IO_BITS = 32;

endpackage

@@ rtl/core/cau_cell.sv @@
// one restoring-division cell: one quotient bit for both result parts per stage
// depends on nothing; instantiated in a row by complex_arithmetic_unit
`timescale 1ns / 1ps
module cau_cell #(
  parameter int unsigned DW = 64,
  parameter int unsigned QW = 81,
  parameter int unsigned XW = 71
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [DW-1:0] d_i,
  input  logic [QW-1:0] n_re_i,
  input  logic [QW-1:0] n_im_i,
  input  logic [DW-1:0] r_re_i,
  input  logic [DW-1:0] r_im_i,
  input  logic [QW-1:0] q_re_i,
  input  logic [QW-1:0] q_im_i,
  input  logic [XW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] d_o,
  output logic [QW-1:0] n_re_o,
  output logic [QW-1:0] n_im_o,
  output logic [DW-1:0] r_re_o,
  output logic [DW-1:0] r_im_o,
  output logic [QW-1:0] q_re_o,
  output logic [QW-1:0] q_im_o,
  output logic [XW-1:0] side_o
);

  logic [DW:0]   t_re, t_im, dif_re, dif_im;
  logic          ge_re, ge_im;
  logic [DW-1:0] r_re_d, r_im_d;

  always_comb begin
    t_re   = {r_re_i, n_re_i[QW-1]};
    t_im   = {r_im_i, n_im_i[QW-1]};
    ge_re  = t_re >= {1'b0, d_i};
    ge_im  = t_im >= {1'b0, d_i};
    dif_re = t_re - {1'b0, d_i};
    dif_im = t_im - {1'b0, d_i};
    r_re_d = ge_re ? dif_re[DW-1:0] : t_re[DW-1:0];
    r_im_d = ge_im ? dif_im[DW-1:0] : t_im[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_o    <= d_i;
    n_re_o <= {n_re_i[QW-2:0], 1'b0};
    n_im_o <= {n_im_i[QW-2:0], 1'b0};
    r_re_o <= r_re_d;
    r_im_o <= r_im_d;
    q_re_o <= {q_re_i[QW-2:0], ge_re};
    q_im_o <= {q_im_i[QW-2:0], ge_im};
    side_o <= side_i;
  end

endmodule

@@ rtl/core/complex_arithmetic_unit.sv @@
// top level: one complex operation per cycle, products up front, then a row of
// division cells, then saturation; depends on cau_pkg and cau_cell
// throughput: one transaction per cycle for every operation, busy stays low
// the division cell row, one quotient bit per cell, sets the latency
// reset: asynchronous, clears the valid bits of every stage; the receiver cannot stall
`timescale 1ns / 1ps
module complex_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation_i,
  input  logic signed [31:0] a_re_i,
  input  logic signed [31:0] a_im_i,
  input  logic signed [31:0] b_re_i,
  input  logic signed [31:0] b_im_i,
  output logic               valid_o,
  output logic signed [31:0] res_re_o,
  output logic signed [31:0] res_im_o,
  output logic               compare_true_o,
  output logic [1:0]         status_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned QW = SW + F;
  localparam int unsigned XW = 2 * W + 7;
  localparam int unsigned HF = (F > 0) ? F - 1 : 0;
  localparam logic [SW-1:0] HALF = (F > 0) ? (SW'(1) << HF) : '0;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W:0] sat_wide(input logic signed [SW-1:0] v);
    logic fits;
    fits = (v[SW-1:W-1] == '0) || (v[SW-1:W-1] == '1);
    if (fits) begin
      return {1'b0, v[W-1:0]};
    end
    return {1'b1, v[SW-1] ? MINV : MAXV};
  endfunction

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: operand capture
  logic                s1_valid_q;
  cau_pkg::op_e        s1_op_q;
  logic signed [W-1:0] s1_ar_q, s1_ai_q, s1_br_q, s1_bi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q <= cau_pkg::op_e'(operation_i);
      s1_ar_q <= a_re_i[W-1:0];
      s1_ai_q <= a_im_i[W-1:0];
      s1_br_q <= b_re_i[W-1:0];
      s1_bi_q <= b_im_i[W-1:0];
    end
  end

  // stage 2: products, sums and equality
  logic                 s2_valid_q;
  cau_pkg::op_e         s2_op_q;
  logic signed [PW-1:0] s2_rr_q, s2_ii_q, s2_ri_q, s2_ir_q, s2_bbr_q, s2_bbi_q;
  logic signed [W:0]    s2_sre_q, s2_sim_q;
  logic                 s2_eq_q;
  logic signed [W:0]    ar_x, ai_x, br_x, bi_x, sre_d, sim_d;

  always_comb begin
    ar_x = s1_ar_q;
    ai_x = s1_ai_q;
    br_x = s1_br_q;
    bi_x = s1_bi_q;
    if (s1_op_q == cau_pkg::OP_SUB) begin
      sre_d = ar_x - br_x;
      sim_d = ai_x - bi_x;
    end else begin
      sre_d = ar_x + br_x;
      sim_d = ai_x + bi_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_op_q  <= s1_op_q;
    s2_rr_q  <= s1_ar_q * s1_br_q;
    s2_ii_q  <= s1_ai_q * s1_bi_q;
    s2_ri_q  <= s1_ar_q * s1_bi_q;
    s2_ir_q  <= s1_ai_q * s1_br_q;
    s2_bbr_q <= s1_br_q * s1_br_q;
    s2_bbi_q <= s1_bi_q * s1_bi_q;
    s2_sre_q <= sre_d;
    s2_sim_q <= sim_d;
    s2_eq_q  <= (s1_ar_q == s1_br_q) && (s1_ai_q == s1_bi_q);
  end

  // stage 3: product sums
  logic                 s3_valid_q;
  cau_pkg::op_e         s3_op_q;
  logic signed [SW-1:0] s3_mre_q, s3_mim_q, s3_nre_q, s3_nim_q;
  logic [PW-1:0]        s3_d_q;
  logic signed [W:0]    s3_sre_q, s3_sim_q;
  logic                 s3_eq_q;
  logic signed [SW-1:0] rr_x, ii_x, ri_x, ir_x;

  always_comb begin
    rr_x = s2_rr_q;
    ii_x = s2_ii_q;
    ri_x = s2_ri_q;
    ir_x = s2_ir_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_op_q  <= s2_op_q;
    s3_mre_q <= rr_x - ii_x;
    s3_mim_q <= ri_x + ir_x;
    s3_nre_q <= rr_x + ii_x;
    s3_nim_q <= ir_x - ri_x;
    s3_d_q   <= PW'(unsigned'(s2_bbr_q)) + PW'(unsigned'(s2_bbi_q));
    s3_sre_q <= s2_sre_q;
    s3_sim_q <= s2_sim_q;
    s3_eq_q  <= s2_eq_q;
  end

  // rounding, saturation and dividend setup feeding the first cell
  logic signed [SW-1:0] rnd_re, rnd_im, sw_re, sw_im;
  logic [SW-1:0]        mag_re, mag_im;
  logic [W:0]           st_re, st_im;
  logic                 is_div, dz, neg_re, neg_im, cmp;
  cau_pkg::status_e     st0;
  logic [W-1:0]         v_re, v_im;
  logic [XW-1:0]        side0;
  logic [QW-1:0]        n0_re, n0_im;

  always_comb begin
    rnd_re = (s3_mre_q + signed'(HALF)) >>> F;
    rnd_im = (s3_mim_q + signed'(HALF)) >>> F;
    sw_re  = s3_sre_q;
    sw_im  = s3_sim_q;
    neg_re = s3_nre_q[SW-1];
    neg_im = s3_nim_q[SW-1];
    mag_re = neg_re ? -s3_nre_q : s3_nre_q;
    mag_im = neg_im ? -s3_nim_q : s3_nim_q;
    n0_re  = QW'(mag_re) << F;
    n0_im  = QW'(mag_im) << F;
    is_div = 1'b0;
    dz     = 1'b0;
    cmp    = 1'b0;
    st_re  = '0;
    st_im  = '0;
    unique case (s3_op_q)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        st_re = sat_wide(sw_re);
        st_im = sat_wide(sw_im);
      end
      cau_pkg::OP_MUL: begin
        st_re = sat_wide(rnd_re);
        st_im = sat_wide(rnd_im);
      end
      cau_pkg::OP_DIV: begin
        is_div = 1'b1;
        dz     = (s3_d_q == '0);
      end
      cau_pkg::OP_EQ: cmp = s3_eq_q;
      cau_pkg::OP_NE: cmp = !s3_eq_q;
      default: ;
    endcase
    v_re  = st_re[W-1:0];
    v_im  = st_im[W-1:0];
    st0   = (st_re[W] || st_im[W]) ? cau_pkg::ST_OVERFLOW : cau_pkg::ST_OK;
    side0 = {is_div, dz, neg_re, neg_im, cmp, st0, v_re, v_im};
  end

  // division cell row
  logic          cv   [0:QW];
  logic [PW-1:0] cd   [0:QW];
  logic [QW-1:0] cnre [0:QW];
  logic [QW-1:0] cnim [0:QW];
  logic [PW-1:0] crre [0:QW];
  logic [PW-1:0] crim [0:QW];
  logic [QW-1:0] cqre [0:QW];
  logic [QW-1:0] cqim [0:QW];
  logic [XW-1:0] cx   [0:QW];

  assign cv[0]   = s3_valid_q;
  assign cd[0]   = s3_d_q;
  assign cnre[0] = n0_re;
  assign cnim[0] = n0_im;
  assign crre[0] = '0;
  assign crim[0] = '0;
  assign cqre[0] = '0;
  assign cqim[0] = '0;
  assign cx[0]   = side0;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    cau_cell #(.DW(PW), .QW(QW), .XW(XW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .d_i     (cd[i]),
      .n_re_i  (cnre[i]),
      .n_im_i  (cnim[i]),
      .r_re_i  (crre[i]),
      .r_im_i  (crim[i]),
      .q_re_i  (cqre[i]),
      .q_im_i  (cqim[i]),
      .side_i  (cx[i]),
      .valid_o (cv[i+1]),
      .d_o     (cd[i+1]),
      .n_re_o  (cnre[i+1]),
      .n_im_o  (cnim[i+1]),
      .r_re_o  (crre[i+1]),
      .r_im_o  (crim[i+1]),
      .q_re_o  (cqre[i+1]),
      .q_im_o  (cqim[i+1]),
      .side_o  (cx[i+1])
    );
  end

  // final selection and quotient saturation
  logic [XW-1:0]       xs;
  logic [QW-1:0]       q_re, q_im;
  logic                f_div, f_dz, f_nre, f_nim, f_cmp;
  logic [1:0]          f_st;
  logic [W-1:0]        f_re, f_im;
  logic                hi_re, hi_im, mn_re, mn_im, ov_re, ov_im;
  logic [W-1:0]        qv_re, qv_im;
  logic signed [W-1:0] o_re, o_im;
  logic                o_cmp;
  logic [1:0]          o_st;

  always_comb begin
    xs    = cx[QW];
    q_re  = cqre[QW];
    q_im  = cqim[QW];
    {f_div, f_dz, f_nre, f_nim, f_cmp, f_st, f_re, f_im} = xs;
    hi_re = |q_re[QW-1:W-1];
    hi_im = |q_im[QW-1:W-1];
    // magnitude of exactly 2^(W-1) still fits when negative
    mn_re = (q_re[QW-1:W-1] == (QW-W+1)'(1)) && (q_re[W-2:0] == '0);
    mn_im = (q_im[QW-1:W-1] == (QW-W+1)'(1)) && (q_im[W-2:0] == '0);
    ov_re = f_nre ? (hi_re && !mn_re) : hi_re;
    ov_im = f_nim ? (hi_im && !mn_im) : hi_im;
    qv_re = ov_re ? (f_nre ? MINV : MAXV) : (f_nre ? -q_re[W-1:0] : q_re[W-1:0]);
    qv_im = ov_im ? (f_nim ? MINV : MAXV) : (f_nim ? -q_im[W-1:0] : q_im[W-1:0]);
    o_cmp = f_cmp;
    if (f_div && f_dz) begin
      o_re = '0;
      o_im = '0;
      o_st = cau_pkg::ST_DIV_ZERO;
    end else if (f_div) begin
      o_re = qv_re;
      o_im = qv_im;
      o_st = (ov_re || ov_im) ? cau_pkg::ST_OVERFLOW : cau_pkg::ST_OK;
    end else begin
      o_re = f_re;
      o_im = f_im;
      o_st = f_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= cv[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    res_re_o       <= cau_pkg::IO_BITS'(o_re);
    res_im_o       <= cau_pkg::IO_BITS'(o_im);
    compare_true_o <= o_cmp;
    status_o       <= o_st;
  end

endmodule

@@ rtl/core/cau_checker.sv @@
// port-level checks of complex_arithmetic_unit and the bind that attaches them
// depends on cau_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cau_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        valid_o,
  input logic [31:0] res_re_o,
  input logic [31:0] res_im_o,
  input logic        compare_true_o,
  input logic [1:0]  status_o
);

  `CAU_ASSERT(a_never_busy, clk_i, rst_ni, !busy)
  `CAU_ASSERT_IMP(a_status_code, clk_i, rst_ni, valid_o, status_o != 2'd3)
  `CAU_ASSERT_IMP(a_cmp_clean, clk_i, rst_ni, valid_o && compare_true_o, (res_re_o == '0) && (res_im_o == '0) && (status_o == cau_pkg::ST_OK))
  `CAU_ASSERT_IMP(a_dz_clean, clk_i, rst_ni, valid_o && (status_o == cau_pkg::ST_DIV_ZERO), (res_re_o == '0) && (res_im_o == '0) && !compare_true_o)

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .valid_o        (valid_o),
  .res_re_o       (res_re_o),
  .res_im_o       (res_im_o),
  .compare_true_o (compare_true_o),
  .status_o       (status_o)
);
